// ----- rtl/scl_pkg.sv -----
// ----------------------------------------------------------------------------
// scl_pkg: shared types and constants for the serial command line parser
// Holds the size limits, result codes, parse phases and the action lookup.
// ----------------------------------------------------------------------------
package scl_pkg;

    // Size limits of a command line
    localparam int MAX_CMD_LEN   = 11;
    localparam int MAX_VALUE_LEN = 6;
    localparam int FRAC_DIGITS   = 4;
    localparam int MIN_CMD_LEN   = 4;
    localparam int ACTION_LEN    = 3;

    // Field and counter widths
    localparam int CH_W      = 8;
    localparam int CMD_W     = 4;
    localparam int STAT_W    = 3;
    localparam int INT_W     = 21;
    localparam int FIX_W     = 35;
    localparam int INT_MAG_W = INT_W - 1;
    localparam int FIX_MAG_W = FIX_W - 1;
    localparam int CNT_W     = $clog2(MAX_CMD_LEN + 2);
    localparam int VLEN_W    = $clog2(MAX_VALUE_LEN + 2);
    localparam int FRAC_W    = $clog2(FRAC_DIGITS + 1);
    localparam int SCALE_W   = $clog2(10 ** FRAC_DIGITS + 1);

    localparam logic [INT_MAG_W-1:0] INT_MAG_MAX = '1;
    localparam logic [FIX_MAG_W-1:0] FIX_MAG_MAX = '1;

    // Character codes
    localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [CH_W-1:0] CH_LC_Z  = 8'h7A;
    localparam logic [CH_W-1:0] CASE_OFS = 8'h20;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE = 4'd0,
        CMD_UTT  = 4'd1,
        CMD_UTB  = 4'd2,
        CMD_RCT  = 4'd3,
        CMD_RRS  = 4'd4,
        CMD_URS  = 4'd5,
        CMD_RSI  = 4'd6,
        CMD_RRI  = 4'd7,
        CMD_HBS  = 4'd8,
        CMD_LTS  = 4'd9
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK             = 3'd0,
        ST_BAD_LEN        = 3'd1,
        ST_NO_COLON       = 3'd2,
        ST_BAD_ACTION_LEN = 3'd3,
        ST_VALUE_LONG     = 3'd4,
        ST_ZERO_VALUE     = 3'd5,
        ST_UNKNOWN_ACTION = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        PH_BLANK,
        PH_SIGN,
        PH_INT,
        PH_FRAC,
        PH_DONE
    } t_phase;

    // Finished line, handed from the character stage to the result stage
    typedef struct packed {
        t_cmd                 command;
        t_status              status;
        logic                 negative;
        logic [INT_MAG_W-1:0] int_mag;
        logic [FIX_MAG_W-1:0] fix_mag;
        logic [FRAC_W-1:0]    frac;
    } t_fin;

    // Fold a letter to upper case
    function automatic logic [CH_W-1:0] to_upper(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] u;
        u = c;
        if (c >= CH_LC_A && c <= CH_LC_Z) begin
            u = c - CASE_OFS;
        end
        return u;
    endfunction

    // Map the three action letters to a command code
    function automatic t_cmd lookup_action(input logic [CH_W-1:0] a0,
                                           input logic [CH_W-1:0] a1,
                                           input logic [CH_W-1:0] a2);
        logic [3*CH_W-1:0] key;
        t_cmd              cmd;
        key = {to_upper(a0), to_upper(a1), to_upper(a2)};
        case (key)
            "UTT":   cmd = CMD_UTT;
            "UTB":   cmd = CMD_UTB;
            "RCT":   cmd = CMD_RCT;
            "RRS":   cmd = CMD_RRS;
            "URS":   cmd = CMD_URS;
            "RSI":   cmd = CMD_RSI;
            "RRI":   cmd = CMD_RRI;
            "HBS":   cmd = CMD_HBS;
            "LTS":   cmd = CMD_LTS;
            default: cmd = CMD_NONE;
        endcase
        return cmd;
    endfunction

    // Power of ten that fills the missing fraction digits
    function automatic logic [SCALE_W-1:0] scale_for(input logic [FRAC_W-1:0] f);
        logic [SCALE_W-1:0] s;
        s = SCALE_W'(1);
        for (int i = 0; i < FRAC_DIGITS; i++) begin
            if (i >= int'(f)) begin
                s = SCALE_W'(s * 10);
            end
        end
        return s;
    endfunction

endpackage

// ----- rtl/serial_command_line_parser.sv -----
// ----------------------------------------------------------------------------
// serial_command_line_parser: character-serial command line parser
// Collects an AAA:VALUE line one character per request and gives one
// checked result (command, status, integer and fixed-point value) per line.
// ----------------------------------------------------------------------------
//
//  channel | signals                                 | direction
//  --------+-----------------------------------------+----------
//  in      | i_in_valid, o_in_ready, i_ch, i_last     | request in
//  out     | o_out_valid, i_out_ready, o_command,     | result out
//          | o_status, o_int_value, o_fixed_value     |
//
//  One character is taken every cycle unless a line end waits for a full
//  finish register; the line state is updated in one pass. The character with
//  i_last passes the input register, line state with finish register, and
//  scaling multiplier with output register. Each stage holds while the next
//  is full, so a stalled result does not block new characters until the
//  finish register fills too. i_rst_n is synchronous, active low, and clears
//  all valid bits and the line state.
//
module serial_command_line_parser
    import scl_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [CH_W-1:0]         i_ch,
    input  logic                    i_last,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [CMD_W-1:0]        o_command,
    output logic [STAT_W-1:0]       o_status,
    output logic signed [INT_W-1:0] o_int_value,
    output logic signed [FIX_W-1:0] o_fixed_value
);

    // Input register
    logic            r_s1_valid;
    logic [CH_W-1:0] r_s1_ch;
    logic            r_s1_last;

    // Line state
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [CNT_W-1:0]     r_colon_pos, n_colon_pos;
    logic                 r_colon_seen, n_colon_seen;
    logic [CH_W-1:0]      r_act [ACTION_LEN];
    logic [CH_W-1:0]      n_act [ACTION_LEN];
    logic [VLEN_W-1:0]    r_vlen, n_vlen;
    t_phase               r_phase, n_phase;
    logic                 r_neg, n_neg;
    logic [INT_MAG_W-1:0] r_int_acc, n_int_acc;
    logic [FIX_MAG_W-1:0] r_fix_acc, n_fix_acc;
    logic [FRAC_W-1:0]    r_frac, n_frac;
    logic                 r_nonzero, n_nonzero;

    // Finish and output registers
    logic r_fin_valid;
    t_fin r_fin, n_fin;
    logic                    r_out_valid;
    logic [CMD_W-1:0]        r_out_command;
    logic [STAT_W-1:0]       r_out_status;
    logic signed [INT_W-1:0] r_out_int;
    logic signed [FIX_W-1:0] r_out_fix;

    // Flow control
    logic out_free, fin_adv, fin_free, s1_adv;

    assign out_free   = !r_out_valid || i_out_ready;
    assign fin_adv    = r_fin_valid && out_free;
    assign fin_free   = !r_fin_valid || out_free;
    assign s1_adv     = r_s1_valid && (!r_s1_last || fin_free);
    assign o_in_ready = !r_s1_valid || s1_adv;

    // Capture the incoming character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
        if (i_in_valid && o_in_ready) begin
            r_s1_ch   <= i_ch;
            r_s1_last <= i_last;
        end
    end

    // Character classes
    logic                 is_digit, is_blank;
    logic [3:0]           digit;
    logic [INT_MAG_W+3:0] int_ext;
    logic [FIX_MAG_W+3:0] fix_ext;
    logic [INT_MAG_W-1:0] int_step;
    logic [FIX_MAG_W-1:0] fix_step;

    assign is_digit = (r_s1_ch >= CH_ZERO) && (r_s1_ch <= CH_NINE);
    assign is_blank = (r_s1_ch == CH_SPACE) || ((r_s1_ch >= CH_TAB) && (r_s1_ch <= CH_CR));
    assign digit    = is_digit ? 4'(r_s1_ch - CH_ZERO) : 4'd0;

    // Multiply-by-ten accumulate, saturating
    assign int_ext  = (INT_MAG_W+4)'(r_int_acc) * (INT_MAG_W+4)'(10)
                    + (INT_MAG_W+4)'(digit);
    assign fix_ext  = (FIX_MAG_W+4)'(r_fix_acc) * (FIX_MAG_W+4)'(10)
                    + (FIX_MAG_W+4)'(digit);
    assign int_step = (int_ext > (INT_MAG_W+4)'(INT_MAG_MAX)) ? INT_MAG_MAX
                                                               : int_ext[INT_MAG_W-1:0];
    assign fix_step = (fix_ext > (FIX_MAG_W+4)'(FIX_MAG_MAX)) ? FIX_MAG_MAX
                                                               : fix_ext[FIX_MAG_W-1:0];

    // Next line state for the character in the input register
    always_comb begin
        logic take_int, take_frac;
        take_int  = 1'b0;
        take_frac = 1'b0;

        n_cnt        = (r_cnt < CNT_W'(MAX_CMD_LEN + 1)) ? r_cnt + 1'b1 : r_cnt;
        n_colon_pos  = r_colon_pos;
        n_colon_seen = r_colon_seen;
        n_act        = r_act;
        n_vlen       = r_vlen;
        n_phase      = r_phase;
        n_neg        = r_neg;
        n_int_acc    = r_int_acc;
        n_fix_acc    = r_fix_acc;
        n_frac       = r_frac;
        n_nonzero    = r_nonzero;

        if (!r_colon_seen) begin
            if (r_s1_ch == CH_COLON) begin
                n_colon_seen = 1'b1;
                n_colon_pos  = r_cnt;
            end else begin
                for (int i = 0; i < ACTION_LEN; i++) begin
                    if (r_cnt == CNT_W'(i)) begin
                        n_act[i] = r_s1_ch;
                    end
                end
            end
        end else begin
            if (r_vlen < VLEN_W'(MAX_VALUE_LEN + 1)) begin
                n_vlen = r_vlen + 1'b1;
            end
            case (r_phase)
                PH_BLANK: begin
                    if (is_blank) begin
                        n_phase = PH_BLANK;
                    end else if (r_s1_ch == CH_PLUS || r_s1_ch == CH_MINUS) begin
                        n_neg   = (r_s1_ch == CH_MINUS);
                        n_phase = PH_SIGN;
                    end else if (is_digit) begin
                        n_phase  = PH_INT;
                        take_int = 1'b1;
                    end else if (r_s1_ch == CH_DOT) begin
                        n_phase = PH_FRAC;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_SIGN, PH_INT: begin
                    if (is_digit) begin
                        n_phase  = PH_INT;
                        take_int = 1'b1;
                    end else if (r_s1_ch == CH_DOT) begin
                        n_phase = PH_FRAC;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_FRAC: begin
                    if (is_digit) begin
                        take_frac = 1'b1;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        // Take a digit into the accumulators
        if ((take_int || take_frac) && digit != 4'd0) begin
            n_nonzero = 1'b1;
        end
        if (take_int) begin
            n_int_acc = int_step;
            n_fix_acc = fix_step;
        end
        if (take_frac && r_frac < FRAC_W'(FRAC_DIGITS)) begin
            n_fix_acc = fix_step;
            n_frac    = r_frac + 1'b1;
        end
    end

    // Check the finished line in order of priority
    always_comb begin
        t_cmd cmd;
        cmd           = lookup_action(n_act[0], n_act[1], n_act[2]);
        n_fin         = '0;
        n_fin.command = CMD_NONE;
        n_fin.status  = ST_OK;
        if (n_cnt < CNT_W'(MIN_CMD_LEN) || n_cnt > CNT_W'(MAX_CMD_LEN)) begin
            n_fin.status = ST_BAD_LEN;
        end else if (!n_colon_seen) begin
            n_fin.status = ST_NO_COLON;
        end else if (n_colon_pos != CNT_W'(ACTION_LEN)) begin
            n_fin.status = ST_BAD_ACTION_LEN;
        end else if (n_vlen > VLEN_W'(MAX_VALUE_LEN)) begin
            n_fin.status = ST_VALUE_LONG;
        end else if (n_vlen != '0 && !n_nonzero) begin
            n_fin.status = ST_ZERO_VALUE;
        end else if (cmd == CMD_NONE) begin
            n_fin.status = ST_UNKNOWN_ACTION;
        end else begin
            n_fin.command = cmd;
        end
        n_fin.negative = n_neg;
        n_fin.int_mag  = n_int_acc;
        n_fin.fix_mag  = n_fix_acc;
        n_fin.frac     = n_frac;
    end

    // Advance the line state; clear it after the final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s1_adv && r_s1_last)) begin
            r_cnt        <= '0;
            r_colon_pos  <= '0;
            r_colon_seen <= 1'b0;
            r_act        <= '{default: '0};
            r_vlen       <= '0;
            r_phase      <= PH_BLANK;
            r_neg        <= 1'b0;
            r_int_acc    <= '0;
            r_fix_acc    <= '0;
            r_frac       <= '0;
            r_nonzero    <= 1'b0;
        end else if (s1_adv) begin
            r_cnt        <= n_cnt;
            r_colon_pos  <= n_colon_pos;
            r_colon_seen <= n_colon_seen;
            r_act        <= n_act;
            r_vlen       <= n_vlen;
            r_phase      <= n_phase;
            r_neg        <= n_neg;
            r_int_acc    <= n_int_acc;
            r_fix_acc    <= n_fix_acc;
            r_frac       <= n_frac;
            r_nonzero    <= n_nonzero;
        end
    end

    // Hold the checked line until the output register takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else begin
            r_fin_valid <= (r_fin_valid && !out_free) || (s1_adv && r_s1_last);
        end
        if (s1_adv && r_s1_last) begin
            r_fin <= n_fin;
        end
    end

    // Scale the fraction to full digits and apply the sign
    logic [FIX_MAG_W+SCALE_W-1:0] fix_prod;
    logic [FIX_MAG_W-1:0]         fix_mag;
    logic signed [INT_W-1:0]      int_signed;
    logic signed [FIX_W-1:0]      fix_signed;
    logic signed [INT_W-1:0]      n_out_int;
    logic signed [FIX_W-1:0]      n_out_fix;

    assign fix_prod   = (FIX_MAG_W+SCALE_W)'(r_fin.fix_mag)
                      * (FIX_MAG_W+SCALE_W)'(scale_for(r_fin.frac));
    assign fix_mag    = (fix_prod > (FIX_MAG_W+SCALE_W)'(FIX_MAG_MAX)) ? FIX_MAG_MAX
                                                                       : fix_prod[FIX_MAG_W-1:0];
    assign int_signed = r_fin.negative ? -$signed({1'b0, r_fin.int_mag})
                                       : $signed({1'b0, r_fin.int_mag});
    assign fix_signed = r_fin.negative ? -$signed({1'b0, fix_mag})
                                       : $signed({1'b0, fix_mag});

    // Route the value by command group
    always_comb begin
        n_out_int = '0;
        n_out_fix = '0;
        case (r_fin.command)
            CMD_UTT, CMD_UTB: begin
                n_out_fix = fix_signed;
            end
            CMD_RCT, CMD_RRS, CMD_URS, CMD_RSI, CMD_RRI: begin
                n_out_int = int_signed;
            end
            default: begin
                n_out_int = '0;
                n_out_fix = '0;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (fin_adv) begin
            r_out_command <= r_fin.command;
            r_out_status  <= r_fin.status;
            r_out_int     <= n_out_int;
            r_out_fix     <= n_out_fix;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_command     = r_out_command;
    assign o_status      = r_out_status;
    assign o_int_value   = r_out_int;
    assign o_fixed_value = r_out_fix;

    // A failed check gives no command and no value
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |->
        (r_out_command == CMD_NONE && r_out_int == '0 && r_out_fix == '0))
        else $error("error result carries a command or a value");

    // Fixed-point commands (UTT, UTB) never carry an integer
    a_fix_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_command == CMD_UTT || r_out_command == CMD_UTB)) |->
        (r_out_int == '0))
        else $error("fixed-point command carries an integer value");

    // The final character leaves a cleared line state behind
    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_last) |=>
        (r_cnt == '0 && r_phase == PH_BLANK && !r_colon_seen && r_vlen == '0))
        else $error("line state not cleared after final character");

    // A stalled finished line is kept
    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin_valid && !out_free) |=> (r_fin_valid && $stable(r_fin)))
        else $error("finished line lost while output stalled");

    // A line end is never taken while the finish register stays full
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last && r_fin_valid && !out_free) |-> !s1_adv)
        else $error("finished line overwritten");

endmodule
